/* sv/s2lab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_pkg: shared types, constants and ROM builder
// Fixed-point constants for the sRGB to CIELAB (D50) datapath.
// ----------------------------------------------------------------------------
package s2lab_pkg;

	// linear component, unsigned Q1.16
	typedef logic [16:0] lin_t;
	typedef lin_t lin_rom_t [256];

	// white-scaled XYZ item passed to the Lab stage
	typedef struct packed {
		logic [16:0] x;
		logic [16:0] y;
		logic [16:0] z;
	} xyz_t;

	// running state of the restoring cube root
	typedef struct packed {
		logic [20:0] y;
		logic [41:0] y2;
		logic [62:0] y3;
	} cbrt_t;

	// matrix coefficients, Q0.16
	localparam logic [15:0] KXR = 16'd28577;
	localparam logic [15:0] KXG = 16'd25237;
	localparam logic [15:0] KXB = 16'd9377;
	localparam logic [15:0] KYR = 16'd14581;
	localparam logic [15:0] KYG = 16'd46982;
	localparam logic [15:0] KYB = 16'd3973;
	localparam logic [15:0] KZR = 16'd913;
	localparam logic [15:0] KZG = 16'd6363;
	localparam logic [15:0] KZB = 16'd46805;

	// white point divisors and their floor reciprocals
	localparam logic [15:0] WHITE_X = 16'd63191;
	localparam logic [15:0] WHITE_Z = 16'd54081;
	localparam logic [32:0] RECIP_X = 33'((64'd1 << 48) / 64'd63191);
	localparam logic [32:0] RECIP_Z = 33'((64'd1 << 48) / 64'd54081);

	// linear segment of f(t)
	localparam logic [11:0] LIN_DIV   = 12'd3132;
	localparam logic [32:0] RECIP_L   = 33'((64'd1 << 44) / 64'd3132);
	localparam logic [29:0] LIN_MUL   = 30'd390224;
	localparam logic [29:0] LIN_OFS   = 30'd452984832;
	localparam logic [31:0] KNEE      = 32'd14155776;
	localparam logic [14:0] KNEE_MUL  = 15'd24389;

	// Lab output scaling
	localparam logic [11:0] L_MUL     = 12'd2958;
	localparam logic [12:0] L_OFS     = 13'd403;
	localparam logic [12:0] RECIP_10  = 13'd6554;

	localparam logic [20:0] F_ONE     = 21'd1048576;
	localparam logic [16:0] T_MAX     = 17'd65536;
	localparam int          CBRT_STEPS = 21;

	function automatic longint unsigned pow5_q30(input longint unsigned t);
		longint unsigned p;
		p = (t * t) >> 30;
		p = (p * p) >> 30;
		return (p * t) >> 30;
	endfunction

	function automatic longint unsigned root5_q30(input longint unsigned s);
		longint unsigned y;
		longint unsigned cand;
		y = 0;
		for (int b = 30; b >= 0; b--) begin
			cand = y | (64'd1 << b);
			if (cand <= (64'd1 << 30) && pow5_q30(cand) <= s)
				y = cand;
		end
		return y;
	endfunction

	// sRGB decoding curve, one entry per code
	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		longint unsigned lin30;
		longint unsigned v30;
		longint unsigned s30;
		for (int c = 0; c < 256; c++) begin
			if (64'(c) * 64'd100000 <= 64'd1031475) begin
				lin30 = ((64'(c) * 64'd100) << 30) / 64'd329460;
			end else begin
				v30 = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
				s30 = (v30 * v30) >> 30;
				lin30 = (s30 * root5_q30(s30)) >> 30;
			end
			rom[c] = 17'((lin30 + 64'd8192) >> 14);
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage
`default_nettype wire

/* sv/s2lab_xyz.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_xyz: linearisation, RGB to XYZ matrix and white scaling
// Four register stages: ROM, matrix, reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module s2lab_xyz (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	output      logic              out_vld,
	output      s2lab_pkg::xyz_t   xyz
);
	import s2lab_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	lin_t        lr_s1, lg_s1, lb_s1;
	logic [32:0] x_s2, y_s2, z_s2;
	logic [32:0] nx_s3, nz_s3;
	logic [16:0] qx_s3, qz_s3, yr_s3;
	xyz_t        t_s4;

	logic [32:0] nx_c, nz_c, ny_c;
	logic [65:0] px_c, pz_c;
	logic [32:0] rx_c, rz_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: decoding curve lookup
	always_ff @(posedge clk) begin
		lr_s1 <= LIN_ROM[red];
		lg_s1 <= LIN_ROM[green];
		lb_s1 <= LIN_ROM[blue];
	end

	// stage 2: 3x3 matrix, exact Q32 sums
	always_ff @(posedge clk) begin
		x_s2 <= 33'(KXR * lr_s1) + 33'(KXG * lg_s1) + 33'(KXB * lb_s1);
		y_s2 <= 33'(KYR * lr_s1) + 33'(KYG * lg_s1) + 33'(KYB * lb_s1);
		z_s2 <= 33'(KZR * lr_s1) + 33'(KZG * lg_s1) + 33'(KZB * lb_s1);
	end

	// stage 3: rounded quotient estimate, may be one low
	always_comb begin
		nx_c = x_s2 + 33'd31595;
		nz_c = z_s2 + 33'd27040;
		ny_c = y_s2 + 33'd32768;
		px_c = 66'(nx_c) * 66'(RECIP_X);
		pz_c = 66'(nz_c) * 66'(RECIP_Z);
	end

	always_ff @(posedge clk) begin
		nx_s3 <= nx_c;
		nz_s3 <= nz_c;
		qx_s3 <= px_c[64:48];
		qz_s3 <= pz_c[64:48];
		yr_s3 <= ny_c[32:16];
	end

	// stage 4: one correction step
	always_comb begin
		rx_c = nx_s3 - 33'(qx_s3 * WHITE_X);
		rz_c = nz_s3 - 33'(qz_s3 * WHITE_Z);
	end

	always_ff @(posedge clk) begin
		t_s4.x <= (rx_c >= 33'(WHITE_X)) ? qx_s3 + 17'd1 : qx_s3;
		t_s4.z <= (rz_c >= 33'(WHITE_Z)) ? qz_s3 + 17'd1 : qz_s3;
		t_s4.y <= yr_s3;
	end

	assign out_vld = v_s4;
	assign xyz     = t_s4;

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (xyz.x <= T_MAX && xyz.y <= T_MAX && xyz.z <= T_MAX))
		else $error("scaled XYZ above white");

endmodule
`default_nettype wire

/* sv/s2lab_labf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_labf: Lab companding function for one channel
// Restoring cube root, one result bit per stage, linear segment alongside.
// ----------------------------------------------------------------------------
module s2lab_labf (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [16:0] t,
	output      logic        out_vld,
	output      logic [20:0] f
);
	import s2lab_pkg::*;

	logic        v_s   [1:CBRT_STEPS];
	logic [16:0] t_s   [1:CBRT_STEPS];
	cbrt_t       cr_s  [1:CBRT_STEPS];
	logic        sel_s [1:CBRT_STEPS];
	logic [20:0] lf_s  [3:CBRT_STEPS];
	logic [29:0] ln_s1, ln_s2;
	logic [18:0] lq_s2;

	logic [29:0] lrem_c;

	// one trial bit of the cube root, cube kept by shifts and adds
	function automatic cbrt_t cbrt_step(input logic [16:0] tv, input cbrt_t cur,
			input int k);
		logic [63:0] y_w;
		logic [63:0] y2_w;
		logic [63:0] c2;
		logic [63:0] c3;
		logic [63:0] tgt;
		cbrt_t       nxt;
		y_w  = 64'(cur.y);
		y2_w = 64'(cur.y2);
		c2   = y2_w + (y_w << (k + 1)) + (64'd1 << (2 * k));
		c3   = 64'(cur.y3) + (y2_w << k) + (y2_w << (k + 1))
			+ (y_w << (2 * k)) + (y_w << (2 * k + 1)) + (64'd1 << (3 * k));
		tgt  = {3'b000, tv, 44'd0};
		nxt  = cur;
		if (c3 <= tgt) begin
			nxt.y  = cur.y | (21'd1 << k);
			nxt.y2 = c2[41:0];
			nxt.y3 = c3[62:0];
		end
		return nxt;
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= CBRT_STEPS; i++)
				v_s[i] <= 1'b0;
		end else begin
			v_s[1] <= in_vld;
			for (int i = 2; i <= CBRT_STEPS; i++)
				v_s[i] <= v_s[i - 1];
		end
	end

	// cube root stages, most significant bit first
	always_ff @(posedge clk) begin
		t_s[1]   <= t;
		cr_s[1]  <= cbrt_step(t, '0, CBRT_STEPS - 1);
		sel_s[1] <= (32'(t * KNEE_MUL) > KNEE);
		for (int i = 2; i <= CBRT_STEPS; i++) begin
			t_s[i]   <= t_s[i - 1];
			cr_s[i]  <= cbrt_step(t_s[i - 1], cr_s[i - 1], CBRT_STEPS - i);
			sel_s[i] <= sel_s[i - 1];
		end
	end

	// linear segment: only small t uses it, so ten bits of t suffice
	always_comb begin
		lrem_c = ln_s2 - 30'(lq_s2 * LIN_DIV);
	end

	always_ff @(posedge clk) begin
		ln_s1 <= 30'(LIN_MUL * 30'(t[9:0])) + LIN_OFS;
		ln_s2 <= ln_s1;
		lq_s2 <= 19'((63'(ln_s1) * 63'(RECIP_L)) >> 44);
		lf_s[3] <= (lrem_c >= 30'(LIN_DIV)) ? 21'(lq_s2) + 21'd1 : 21'(lq_s2);
		for (int i = 4; i <= CBRT_STEPS; i++)
			lf_s[i] <= lf_s[i - 1];
	end

	assign out_vld = v_s[CBRT_STEPS];
	assign f       = sel_s[CBRT_STEPS] ? cr_s[CBRT_STEPS].y : lf_s[CBRT_STEPS];

	a_f_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (f <= F_ONE))
		else $error("f(t) above one");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && sel_s[CBRT_STEPS]) |->
			(cr_s[CBRT_STEPS].y3 <= {2'b00, t_s[CBRT_STEPS], 44'd0}))
		else $error("cube root overshoots");

endmodule
`default_nettype wire

/* sv/s2lab_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_out: final L, a, b scaling with rounding and saturation
// Two register stages: products, then shift, divide by ten and clamp.
// ----------------------------------------------------------------------------
module s2lab_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [20:0]       fx,
	input  wire logic [20:0]       fy,
	input  wire logic [20:0]       fz,
	output      logic              out_vld,
	output      logic [7:0]        lightness,
	output      logic signed [7:0] a_star,
	output      logic signed [7:0] b_star
);
	import s2lab_pkg::*;

	logic               v_s1, v_s2;
	logic [31:0]        pl_s1;
	logic signed [31:0] da_s1, db_s1;
	logic [7:0]         l_s2;
	logic signed [7:0]  a_s2, b_s2;

	logic signed [21:0] dxy_c, dyz_c;
	logic signed [12:0] vl_c;
	logic [24:0]        ml_c;
	logic signed [31:0] sa_c, sb_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
		end
	end

	// stage 1: scale products
	always_comb begin
		dxy_c = $signed({1'b0, fx}) - $signed({1'b0, fy});
		dyz_c = $signed({1'b0, fy}) - $signed({1'b0, fz});
	end

	always_ff @(posedge clk) begin
		pl_s1 <= 32'(L_MUL * fy);
		da_s1 <= 32'(dxy_c) * 32'sd500;
		db_s1 <= 32'(dyz_c) * 32'sd200;
	end

	// stage 2: shifts (floor for L, rounded for a and b), divide by ten, saturate
	always_comb begin
		vl_c = $signed({1'b0, pl_s1[31:20]}) - $signed(L_OFS);
		ml_c = 25'(vl_c[11:0] * RECIP_10);
		sa_c = (da_s1 + 32'sd524288) >>> 20;
		sb_c = (db_s1 + 32'sd524288) >>> 20;
	end

	always_ff @(posedge clk) begin
		if (vl_c < 0)
			l_s2 <= 8'd0;
		else if (ml_c[24:16] > 9'd255)
			l_s2 <= 8'd255;
		else
			l_s2 <= ml_c[23:16];

		if (sa_c > 32'sd127)
			a_s2 <= 8'sd127;
		else if (sa_c < -32'sd128)
			a_s2 <= -8'sd128;
		else
			a_s2 <= sa_c[7:0];

		if (sb_c > 32'sd127)
			b_s2 <= 8'sd127;
		else if (sb_c < -32'sd128)
			b_s2 <= -8'sd128;
		else
			b_s2 <= sb_c[7:0];
	end

	assign out_vld   = v_s2;
	assign lightness = l_s2;
	assign a_star    = a_s2;
	assign b_star    = b_s2;

endmodule
`default_nettype wire

/* sv/srgb_to_cielab_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_to_cielab_converter: 8-bit sRGB to 8-bit CIELAB, D50 white
// Fully pipelined colour-space converter, one item per clock.
// ----------------------------------------------------------------------------
// Usage:
//  Drive red, green, blue with start high; the item is taken at that edge.
//  busy is always low, so a new item may be given every cycle.
//  Each result appears on lightness, a_star, b_star for one cycle with done
//  high, after 4 stages for the curve ROM, matrix and white scaling, 21 for
//  the bit-per-stage cube root and 2 for the output scaling. Results come
//  out in order.
//  Throughput is one item per cycle, sustained; no stage is shared.
//  There is no output hold: the receiver must take each result when done
//  is high. Reset clears every valid bit, so no stray done follows reset;
//  items in flight at reset are dropped. The block holds no other state.
// ----------------------------------------------------------------------------
module srgb_to_cielab_converter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	output      logic              done,
	output      logic [7:0]        lightness,
	output      logic signed [7:0] a_star,
	output      logic signed [7:0] b_star
);
	import s2lab_pkg::*;

	logic        xyz_vld;
	xyz_t        xyz;
	logic        fx_vld, fy_vld, fz_vld;
	logic [20:0] fx, fy, fz;

	assign busy = 1'b0;

	// linearise, matrix, white scale
	s2lab_xyz u_xyz (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.out_vld (xyz_vld),
		.xyz     (xyz)
	);

	// companding, one unit per channel
	s2lab_labf u_fx (
		.clk (clk), .arst_n (arst_n), .in_vld (xyz_vld), .t (xyz.x),
		.out_vld (fx_vld), .f (fx)
	);

	s2lab_labf u_fy (
		.clk (clk), .arst_n (arst_n), .in_vld (xyz_vld), .t (xyz.y),
		.out_vld (fy_vld), .f (fy)
	);

	s2lab_labf u_fz (
		.clk (clk), .arst_n (arst_n), .in_vld (xyz_vld), .t (xyz.z),
		.out_vld (fz_vld), .f (fz)
	);

	// output scaling
	s2lab_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (fy_vld),
		.fx        (fx),
		.fy        (fy),
		.fz        (fz),
		.out_vld   (done),
		.lightness (lightness),
		.a_star    (a_star),
		.b_star    (b_star)
	);

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(fx_vld == fy_vld) && (fy_vld == fz_vld))
		else $error("channel pipelines out of step");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fy_vld, 2))
		else $error("done without item");

endmodule
`default_nettype wire
